FILE: sv/mhpq_pkg.sv
// Package for the min-heap priority queue: entry and result layouts,
// command and status codes, and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package mhpq_pkg;

    // One stored entry, urgency in the lowest bits.
    typedef struct packed {
        logic        incremental;
        logic [15:0] request_id;
        logic [2:0]  urgency;
    } entry_t;

    // Command codes carried with each input word.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // One result word before the output register.
    typedef struct packed {
        status_t    status;
        logic [6:0] occupancy;
        entry_t     entry;
    } result_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_DN_ROOT,
        ST_DN_LAST,
        ST_DN_L,
        ST_DN_R,
        ST_FIN,
        ST_RESP
    } state_t;

endpackage

FILE: sv/mhpq_store.sv
// Heap storage: one write port and one read port with registered read data.
// Depends on mhpq_pkg for the entry layout.
`timescale 1ns / 1ps

module mhpq_store #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(CAPACITY)-1:0]   wr_addr,
    input  mhpq_pkg::entry_t              wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
    output mhpq_pkg::entry_t              rd_data_reg
);
    import mhpq_pkg::*;

    entry_t mem [CAPACITY];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/mhpq_ctrl.sv
// Heap sequencer: accepts one command at a time and walks the sift-up or
// sift-down path through the heap storage. Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  mhpq_pkg::entry_t              in_entry,
    output logic                          res_valid,
    input  logic                          res_ready,
    output mhpq_pkg::result_t             res,
    output logic                          mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0]   mem_wr_addr,
    output mhpq_pkg::entry_t              mem_wr_data,
    output logic                          mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0]   mem_rd_addr,
    input  mhpq_pkg::entry_t              mem_rd_data
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = AW + 2;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   pos_reg, pos_next;
    entry_t          e_reg, e_next;
    entry_t          left_reg, left_next;
    entry_t          got_reg, got_next;
    status_t         status_reg, status_next;

    logic [AW-1:0]   in_pos;
    logic [AW-1:0]   in_par;
    logic [AW-1:0]   par_addr;
    logic [AW-1:0]   par_par;
    logic [WW-1:0]   n_w;
    logic [WW-1:0]   lw;
    logic [WW-1:0]   rw;
    logic            left_lt;
    logic [2:0]      best_key;
    logic            right_lt;
    logic [AW-1:0]   child;
    logic [WW-1:0]   child_l;
    logic [CW+6:0]   occ_wide;

    // Index arithmetic for the heap walk.
    assign in_pos   = count_reg[AW-1:0];
    assign in_par   = (in_pos - AW'(1)) >> 1;
    assign par_addr = (pos_reg - AW'(1)) >> 1;
    assign par_par  = (par_addr - AW'(1)) >> 1;
    assign n_w      = WW'(count_reg);
    assign lw       = WW'({pos_reg, 1'b1});
    assign rw       = lw + WW'(1);

    // Child selection: left wins ties, right only if strictly smaller.
    assign left_lt  = left_reg.urgency < e_reg.urgency;
    assign best_key = left_lt ? left_reg.urgency : e_reg.urgency;
    assign right_lt = mem_rd_data.urgency < best_key;
    assign child    = right_lt ? rw[AW-1:0] : lw[AW-1:0];
    assign child_l  = WW'({child, 1'b1});

    assign occ_wide = (CW + 7)'(count_reg);

    // State and data registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        e_reg      <= e_next;
        left_reg   <= left_next;
        got_reg    <= got_next;
        status_reg <= status_next;
    end

    // Next state, memory accesses and result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        e_next      = e_reg;
        left_next   = left_reg;
        got_next    = got_reg;
        status_next = status_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = pos_reg;
        mem_wr_data = e_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        res.status    = status_reg;
        res.occupancy = occ_wide[6:0];
        res.entry     = got_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    got_next    = '0;
                    status_next = STATUS_OK;
                    case (in_cmd)
                        CMD_ENQUEUE:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                                state_next  = ST_RESP;
                            end
                            else
                            begin
                                e_next     = in_entry;
                                pos_next   = in_pos;
                                count_next = count_reg + CW'(1);
                                if (in_pos == '0)
                                begin
                                    state_next = ST_FIN;
                                end
                                else
                                begin
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = in_par;
                                    state_next  = ST_UP_CMP;
                                end
                            end
                        end
                        CMD_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_RESP;
                            end
                            else
                            begin
                                count_next  = count_reg - CW'(1);
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                state_next  = ST_DN_ROOT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Sift up: parent word arrives; move it down if the new key is
            // smaller, and fetch the next parent in the same cycle.
            ST_UP_CMP:
            begin
                if (e_reg.urgency < mem_rd_data.urgency)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pos_reg;
                    mem_wr_data = mem_rd_data;
                    pos_next    = par_addr;
                    if (par_addr == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = par_par;
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            // Dequeue: capture the root and fetch the last entry.
            ST_DN_ROOT:
            begin
                got_next    = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = count_reg[AW-1:0];
                state_next  = ST_DN_LAST;
            end

            // The last entry becomes the hole filler starting at the root.
            ST_DN_LAST:
            begin
                e_next   = mem_rd_data;
                pos_next = '0;
                if (WW'(1) < n_w)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(1);
                    state_next  = ST_DN_L;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            // Left child arrives; fetch the right one if it exists, else move the left child up if it is smaller.
            ST_DN_L:
            begin
                left_next = mem_rd_data;
                if (rw < n_w)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rw[AW-1:0];
                    state_next  = ST_DN_R;
                end
                else
                begin
                    if (mem_rd_data.urgency < e_reg.urgency)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = pos_reg;
                        mem_wr_data = mem_rd_data;
                        pos_next    = lw[AW-1:0];
                    end
                    state_next = ST_FIN;
                end
            end

            // Right child arrives; move the smaller child up if needed.
            ST_DN_R:
            begin
                if (right_lt || left_lt)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pos_reg;
                    mem_wr_data = right_lt ? mem_rd_data : left_reg;
                    pos_next    = child;
                    if (child_l < n_w)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = child_l[AW-1:0];
                        state_next  = ST_DN_L;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            // Drop the carried entry into the hole.
            ST_FIN:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_reg;
                mem_wr_data = e_reg;
                state_next  = ST_RESP;
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("heap count above capacity");

    // The walk never reads and writes the same entry in one cycle.
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
        else $error("read and write to the same heap entry");

    // An accepted command always starts a sequence.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted command did not start");

    // Sift up never compares at the root.
    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_CMP) |-> (pos_reg != '0))
        else $error("sift up at the root");
`endif

endmodule

FILE: sv/min_heap_priority_queue.sv
// Binary min-heap priority queue of CAPACITY entries, each a 3-bit urgency,
// a 16-bit request id and an incremental flag; a lower urgency leaves first
// and equal keys leave in heap order. Every input word (enqueue or dequeue)
// yields one result word with a status, the dequeued entry (zero otherwise)
// and the occupancy after the command. Commands are handled one at a time;
// the heap sits in one memory with one read and one write port, and its
// read port sets the pace. An enqueue compares the entry with one parent
// per level until it stops climbing or reaches the root; a dequeue reads
// the root and the last entry, then the children of each node that the
// moved entry sinks through. A rejected enqueue or an empty dequeue does
// not touch the memory. The result sits in an output register, so a word
// may wait there while the next command is already accepted. Depends on
// mhpq_pkg, mhpq_ctrl and mhpq_store. No memory clearing is needed after
// reset.
`timescale 1ns / 1ps

module min_heap_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // urgency[2:0], request_id[18:3], incremental[19], zero
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_urgency[2:0], out_request_id[18:3],
                                   // out_incremental[19], occupancy[26:20], zero
    output logic [1:0]  m_tuser    // status
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    entry_t        in_entry;
    result_t       res;
    logic          res_valid;
    logic          res_ready;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    entry_t        mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    entry_t        mem_rd_data;
    logic          m_tvalid_reg;
    result_t       res_reg;

    assign in_entry = entry_t'(s_tdata[19:0]);

    mhpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_entry    (in_entry),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    mhpq_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk         (clk),
        .wr_en       (mem_wr_en),
        .wr_addr     (mem_wr_addr),
        .wr_data     (mem_wr_data),
        .rd_en       (mem_rd_en),
        .rd_addr     (mem_rd_addr),
        .rd_data_reg (mem_rd_data)
    );

    // Output register: loads a result word when empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, res_reg.occupancy, res_reg.entry};
    assign m_tuser  = res_reg.status;

endmodule

FILE: test/min_heap_priority_queue_checker.sv
// Checker for the min-heap priority queue: watches both stream channels,
// keeps its own copy of the heap to predict each result word, and compares.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

module min_heap_priority_queue_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // urgency[2:0], request_id[18:3], incremental[19], zero
    input  logic        s_tuser,   // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // out_urgency[2:0], out_request_id[18:3],
                                   // out_incremental[19], occupancy[26:20], zero
    input  logic [1:0]  m_tuser,   // status
    output int          pending,
    output int          mismatches
);

    import mhpq_pkg::*;

    // Shadow heap and its fill level.
    entry_t  shadow_heap [CAPACITY];
    int      shadow_count;
    result_t awaited_words [$];
    int      words_checked;

    // Apply one command to the shadow heap and return the result word it yields.
    function automatic result_t apply_command(logic cmd, entry_t item);
        result_t res;
        entry_t  tmp;
        int      pos;
        int      parent;
        int      best;
        int      left;
        int      right;
        bit      settled;
        res.status = STATUS_OK;
        res.entry  = '0;
        if (cmd == CMD_ENQUEUE)
        begin
            if (shadow_count >= CAPACITY)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                // Place at the tail and climb while strictly smaller than the parent.
                shadow_heap[shadow_count] = item;
                pos = shadow_count;
                settled = 1'b0;
                while (pos > 0 && !settled)
                begin
                    parent = (pos - 1) / 2;
                    if (shadow_heap[pos].urgency < shadow_heap[parent].urgency)
                    begin
                        tmp = shadow_heap[pos];
                        shadow_heap[pos] = shadow_heap[parent];
                        shadow_heap[parent] = tmp;
                        pos = parent;
                    end
                    else
                    begin
                        settled = 1'b1;
                    end
                end
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                // Take the root, move the last entry up and let it sink.
                res.entry = shadow_heap[0];
                shadow_heap[0] = shadow_heap[shadow_count - 1];
                shadow_count--;
                pos = 0;
                settled = 1'b0;
                while (!settled)
                begin
                    best = pos;
                    left = 2 * pos + 1;
                    right = 2 * pos + 2;
                    // Ties keep the left child, the right one must be strictly smaller.
                    if (left < shadow_count &&
                        shadow_heap[left].urgency < shadow_heap[best].urgency)
                        best = left;
                    if (right < shadow_count &&
                        shadow_heap[right].urgency < shadow_heap[best].urgency)
                        best = right;
                    if (best == pos)
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        tmp = shadow_heap[pos];
                        shadow_heap[pos] = shadow_heap[best];
                        shadow_heap[best] = tmp;
                        pos = best;
                    end
                end
            end
        end
        res.occupancy = 7'(shadow_count);
        return res;
    endfunction

    // Count a failure and print it while the report budget lasts.
    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch on word %0d: %s", $realtime, words_checked, msg);
    endtask

    // Results are compared before the input of the same edge is predicted,
    // since a word can never leave on the edge that brought its command in.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        entry_t  got_entry;
        logic    [6:0] got_occ;
        bit      wrong;
        if (!rst_n)
        begin
            shadow_count = 0;
            awaited_words.delete();
            words_checked = 0;
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_entry = m_tdata[19:0];
                got_occ = m_tdata[26:20];
                if (awaited_words.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected word status %0d data %h",
                                            m_tuser, m_tdata));
                end
                else
                begin
                    want = awaited_words.pop_front();
                    wrong = (m_tuser !== want.status) ||
                            (got_entry.urgency !== want.entry.urgency) ||
                            (got_entry.request_id !== want.entry.request_id) ||
                            (got_entry.incremental !== want.entry.incremental) ||
                            (got_occ !== want.occupancy);
                    if (wrong)
                        flag_mismatch($sformatf(
                            {"expected status %0d urg %0d id %h inc %b occ %0d, ",
                             "got status %0d urg %0d id %h inc %b occ %0d"},
                            want.status, want.entry.urgency, want.entry.request_id,
                            want.entry.incremental, want.occupancy,
                            m_tuser, got_entry.urgency, got_entry.request_id,
                            got_entry.incremental, got_occ));
                end
                words_checked++;
            end
            if (s_tvalid && s_tready)
                awaited_words.push_back(apply_command(s_tuser, entry_t'(s_tdata[19:0])));
        end
        pending = awaited_words.size();
    end

endmodule

FILE: test/min_heap_priority_queue_test.sv
// Testbench top for the min-heap priority queue: clock, reset, command
// stimulus, result back-pressure and the verdict.
// Depends on mhpq_pkg, min_heap_priority_queue and min_heap_priority_queue_checker.
`timescale 1ns / 1ps

module min_heap_priority_queue_test;

    import mhpq_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int CMD_TARGET  = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // urgency[2:0], request_id[18:3], incremental[19], zero
    logic        s_tuser = 1'b0;  // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // out_urgency[2:0], out_request_id[18:3],
                                  // out_incremental[19], occupancy[26:20], zero
    logic [1:0]  m_tuser;         // status

    int pending;
    int mismatches;
    int cycle_count = 0;
    int words_taken = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    min_heap_priority_queue #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    min_heap_priority_queue_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always #5 clk = ~clk;

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, bursts without stalls, and two long
    // hold-offs that fill the block up and push back on its input.
    initial
    begin : result_sink
        int hold;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            if (words_taken == 150 || words_taken == 900)
                hold = LONG_HOLD;
            else if (rx_burst)
                hold = 0;
            else
                hold = $urandom_range(0, 12);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            words_taken++;
        end
    end

    // Offer one command word and wait until it is taken.
    task automatic issue_command(logic cmd, logic [2:0] urgency, logic [15:0] request_id,
                                 logic incremental);
        int gap;
        entry_t item;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.urgency = urgency;
        item.request_id = request_id;
        item.incremental = incremental;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, item};
        s_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin : stimulus
        int issued;
        int phase_len;
        int enq_pct;
        int key_top;
        logic cmd;
        logic [15:0] rid;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dequeue, field extremes, ties and a single-entry drain.
        issue_command(CMD_DEQUEUE, 3'd0, 16'h0000, 1'b0);
        issue_command(CMD_ENQUEUE, 3'd7, 16'hFFFF, 1'b1);
        issue_command(CMD_ENQUEUE, 3'd0, 16'h0000, 1'b0);
        issue_command(CMD_ENQUEUE, 3'd0, 16'h1234, 1'b1);
        issue_command(CMD_ENQUEUE, 3'd3, 16'hAAAA, 1'b0);
        issue_command(CMD_ENQUEUE, 3'd3, 16'h5555, 1'b1);
        issue_command(CMD_ENQUEUE, 3'd7, 16'h0001, 1'b0);
        repeat (6) issue_command(CMD_DEQUEUE, 3'd7, 16'hFFFF, 1'b1);
        issue_command(CMD_DEQUEUE, 3'd5, 16'h8000, 1'b1);
        issue_command(CMD_ENQUEUE, 3'd5, 16'hBEEF, 1'b1);
        issue_command(CMD_DEQUEUE, 3'd0, 16'h0000, 1'b0);
        issue_command(CMD_DEQUEUE, 3'd0, 16'h0000, 1'b0);
        issued = 17;

        // Random phases with a fill-heavy, balanced or drain-heavy mix and a
        // narrow or wide key range; the first phase is the most fill-heavy.
        enq_pct = 95;
        while (issued < CMD_TARGET)
        begin
            phase_len = $urandom_range(40, 160);
            tx_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: key_top = 0;
                1: key_top = 1;
                2: key_top = 3;
                default: key_top = 7;
            endcase
            repeat (phase_len)
            begin
                cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
                if ($urandom_range(0, 9) == 0)
                    rid = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    rid = 16'($urandom);
                issue_command(cmd, 3'($urandom_range(0, key_top)), rid,
                              1'($urandom_range(0, 1)));
                issued++;
            end
            case ($urandom_range(0, 2))
                0: enq_pct = 90;
                1: enq_pct = 50;
                default: enq_pct = 15;
            endcase
        end
        s_tvalid <= 1'b0;

        // Let the last words drain, then allow for the block's latency.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/mhpq_pkg.sv
sv/mhpq_store.sv
sv/mhpq_ctrl.sv
sv/min_heap_priority_queue.sv
test/min_heap_priority_queue_checker.sv
test/min_heap_priority_queue_test.sv
